FILE: rtl/core/cell_residency_manager_unit_macros.svh
// Assertion macros shared by the residency manager RTL.
`ifndef CELL_RESIDENCY_MANAGER_UNIT_MACROS_SVH
`define CELL_RESIDENCY_MANAGER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define CRM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent.
`define CRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRM_ASSERT(lbl, clk, rstn, prop, msg)
`define CRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/crm_pkg.sv
// Package with the codes, types and constants of the residency manager.
package crm_pkg;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int COORD_BITS_DEF    = 16;
    localparam int MAX_RESULTS       = 33;
    localparam int FIELD_W           = 16;
    localparam int SLOT_W            = 5;
    localparam int ACT_W             = 6;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_UNLOAD = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_LOAD   = 2'd1;
    localparam logic [1:0] EV_UNLOAD = 2'd2;
    localparam logic [1:0] EV_QUERY  = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOOK    = 9'b000000010,
        S_QANS    = 9'b000000100,
        S_CAND    = 9'b000001000,
        S_LOAD_RD = 9'b000010000,
        S_LOAD    = 9'b000100000,
        S_SW_RD   = 9'b001000000,
        S_SW_CHK  = 9'b010000000,
        S_FINISH  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] event_x;
        logic [FIELD_W-1:0] event_y;
        logic [FIELD_W-1:0] event_z;
        logic               is_loaded;
        logic               slot_found;
        logic [ACT_W-1:0]   active_cells;
        logic               last;
    } t_result;
endpackage

FILE: rtl/core/crm_ifs.sv
// Channel interfaces of the residency manager: requests, results, configuration.
interface crm_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic [15:0] cell_z;
    modport source (output valid, cmd, cell_x, cell_y, cell_z, input ready);
    modport sink   (input valid, cmd, cell_x, cell_y, cell_z, output ready);
endinterface

interface crm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [4:0]  slot;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic [15:0] event_z;
    logic        is_loaded;
    logic        slot_found;
    logic [5:0]  active_cells;
    logic        last;
    modport source (output valid, event_kind, slot, event_x, event_y, event_z,
                    is_loaded, slot_found, active_cells, last, input ready);
    modport sink   (input valid, event_kind, slot, event_x, event_y, event_z,
                    is_loaded, slot_found, active_cells, last, output ready);
endinterface

interface crm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cell_residency_manager_unit.sv
// Cell residency manager: table of grid cells with load and unload sequencing.
//
// Requests arrive on i_cmd. A query request looks its cell up in the table
// (adding it when absent and room remains) and answers with one result. An
// update request gives the player's cell: the cube of half-width load_radius is
// scanned cell by cell, each cell searched in the table at one entry per clock
// through the coordinate memory's read port. The nearest non-resident cell is
// loaded, then the table is swept entry by entry, with a read state and a check
// state for each, and resident cells beyond unload_distance on any axis are
// unloaded. Results leave on o_res, the final one of each request flagged by
// last; an update with nothing to report gives one empty result.
// i_cmd is not ready while a request is at work. Configuration writes on i_cfg
// are taken at any time and must only be issued while idle.
// Reset empties the table, clears all resident flags and restores the register
// defaults at once; the coordinate memory itself is not cleared. When the
// result receiver stalls, the sequencer waits with its next result.
module cell_residency_manager_unit
    import crm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crm_cmd_if.sink    i_cmd,
    crm_res_if.source  o_res,
    crm_cfg_if.sink    i_cfg
);
    `include "cell_residency_manager_unit_macros.svh"

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int CB = COORD_BITS;

    typedef logic [CB-1:0] t_coord;

    // Field conversions between the 16-bit ports and internal coordinates.
    function automatic t_coord from_field(input logic [FIELD_W-1:0] f);
        logic [31:0] t;
        t = 32'(signed'(f));
        return t[CB-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input t_coord c);
        logic [31:0] t;
        t = 32'(c);
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(input logic [AW-1:0] s);
        logic [31:0] t;
        t = 32'(s);
        return t[SLOT_W-1:0];
    endfunction

    function automatic t_coord add_off(input t_coord c, input logic signed [2:0] o);
        return c + {{(CB-3){o[2]}}, o};
    endfunction

    function automatic logic [2:0] mag3(input logic signed [2:0] o);
        return o[2] ? 3'(-o) : 3'(o);
    endfunction

    // Per-axis distance test on the full signed difference.
    function automatic logic beyond(input t_coord e, input t_coord p, input logic [3:0] lim);
        logic signed [CB:0] diff;
        logic [CB:0]        mag;
        diff = signed'({e[CB-1], e}) - signed'({p[CB-1], p});
        mag  = diff[CB] ? (CB+1)'(-diff) : (CB+1)'(diff);
        return mag > (CB+1)'(lim);
    endfunction

    // Configuration registers.
    logic       r_enable;
    logic [1:0] r_radius;
    logic [3:0] r_unload;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_radius <= 2'd1;
            r_unload <= 4'd2;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENABLE: r_enable <= i_cfg.data[0];
                REG_RADIUS: r_radius <= i_cfg.data[1:0];
                REG_UNLOAD: r_unload <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer state and working registers.
    t_state            r_state;
    logic              r_cmd;
    t_coord            r_qx, r_qy, r_qz;
    t_coord            r_cx, r_cy, r_cz;
    logic signed [2:0] r_dx, r_dy, r_dz;
    logic              r_best_ok;
    logic [AW-1:0]     r_best;
    logic [3:0]        r_bestd;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [AW-1:0]     r_pidx;
    logic [AW-1:0]     r_slot;
    logic              r_found;
    logic [CW-1:0]     r_entries;
    logic [TABLE_ENTRIES-1:0] r_res;
    logic [ACT_W-1:0]  r_active;
    logic [ACT_W-1:0]  r_nres;
    logic              r_stg_v;
    t_result           r_stg;
    logic              r_ov;
    t_result           r_out;

    // Coordinate memory, one row per entry, registered read.
    logic [3*CB-1:0] mem [TABLE_ENTRIES];
    logic [3*CB-1:0] r_rd;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    t_coord          rd_x, rd_y, rd_z;

    assign rd_x = r_rd[3*CB-1:2*CB];
    assign rd_y = r_rd[2*CB-1:CB];
    assign rd_z = r_rd[CB-1:0];

    // The chosen entry stays addressed for as long as its load result waits.
    always_comb begin
        unique case (r_state) inside
            S_LOAD_RD, S_LOAD: rd_addr = r_best;
            default:           rd_addr = r_idx[AW-1:0];
        endcase
    end

    // The search resolves when the pending compare hits or all entries missed.
    logic hit, miss, out_free, done_dx, done_dy, done_dz;
    logic signed [2:0] rad_s, nx, ny, nz;
    logic [3:0] cand_d;
    t_result    res_new;
    t_result    fin_res;
    logic       produce;
    logic       stage_en;
    logic       n_ov;

    assign hit  = (r_state == S_LOOK) && r_pend &&
                  rd_x == r_cx && rd_y == r_cy && rd_z == r_cz;
    assign miss = (r_state == S_LOOK) && !r_pend && (r_idx >= r_entries);
    assign wr_en = miss && (r_entries < CW'(TABLE_ENTRIES));
    assign out_free = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_entries[AW-1:0]] <= {r_cx, r_cy, r_cz};
        end
        r_rd <= mem[rd_addr];
    end

    // Next scan offsets in x, then y, then z order.
    assign rad_s   = signed'({1'b0, r_radius});
    assign done_dx = (r_dx >= rad_s);
    assign done_dy = (r_dy >= rad_s);
    assign done_dz = (r_dz >= rad_s);
    assign nx = done_dx ? -rad_s : r_dx + 3'sd1;
    assign ny = done_dx ? (done_dy ? -rad_s : r_dy + 3'sd1) : r_dy;
    assign nz = (done_dx && done_dy) ? r_dz + 3'sd1 : r_dz;
    assign cand_d = 4'(mag3(r_dx)) + 4'(mag3(r_dy)) + 4'(mag3(r_dz));

    // Result built in the current state, if any.
    always_comb begin
        res_new = '0;
        produce = 1'b0;
        unique case (r_state)
            S_QANS: begin
                produce            = 1'b1;
                res_new.event_kind = EV_QUERY;
                res_new.slot       = r_found ? to_slot(r_slot) : '0;
                res_new.event_x    = to_field(r_qx);
                res_new.event_y    = to_field(r_qy);
                res_new.event_z    = to_field(r_qz);
                res_new.is_loaded  = r_found && r_res[r_slot];
                res_new.slot_found = r_found;
                res_new.active_cells = r_active;
            end
            S_LOAD: begin
                produce            = 1'b1;
                res_new.event_kind = EV_LOAD;
                res_new.slot       = to_slot(r_best);
                res_new.event_x    = to_field(rd_x);
                res_new.event_y    = to_field(rd_y);
                res_new.event_z    = to_field(rd_z);
                res_new.is_loaded  = 1'b1;
                res_new.slot_found = 1'b1;
                res_new.active_cells = r_active + 1'b1;
            end
            S_SW_CHK: begin
                produce = r_res[r_idx[AW-1:0]] &&
                          !(r_best_ok && r_best == r_idx[AW-1:0]) &&
                          (beyond(rd_x, r_qx, r_unload) || beyond(rd_y, r_qy, r_unload) ||
                           beyond(rd_z, r_qz, r_unload));
                res_new.event_kind = EV_UNLOAD;
                res_new.slot       = to_slot(r_idx[AW-1:0]);
                res_new.event_x    = to_field(rd_x);
                res_new.event_y    = to_field(rd_y);
                res_new.event_z    = to_field(rd_z);
                res_new.slot_found = 1'b1;
                res_new.active_cells = r_active - 1'b1;
            end
            default: ;
        endcase
    end

    // Final result of a request: the staged one, or an empty one.
    always_comb begin
        if (r_stg_v) begin
            fin_res = r_stg;
        end else begin
            fin_res              = '0;
            fin_res.active_cells = r_active;
        end
        fin_res.last = 1'b1;
    end

    // A result is staged while under the cap; the output register fills or drains.
    assign stage_en = produce && out_free && (r_nres < ACT_W'(MAX_RESULTS));
    assign n_ov     = (stage_en && r_stg_v) || ((r_state == S_FINISH) && out_free) ||
                      (r_ov && !o_res.ready);

    assign i_cmd.ready = (r_state == S_IDLE);

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_entries <= '0;
            r_res     <= '0;
            r_active  <= '0;
            r_nres    <= '0;
            r_stg_v   <= 1'b0;
            r_ov      <= 1'b0;
            r_pend    <= 1'b0;
            r_best_ok <= 1'b0;
        end else begin
            r_ov <= n_ov;

            // A new result retires the staged one to the output register.
            if (stage_en) begin
                r_nres  <= r_nres + 1'b1;
                r_stg   <= res_new;
                r_stg_v <= 1'b1;
                if (r_stg_v) begin
                    r_out <= r_stg;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd     <= i_cmd.cmd;
                        r_qx      <= from_field(i_cmd.cell_x);
                        r_qy      <= from_field(i_cmd.cell_y);
                        r_qz      <= from_field(i_cmd.cell_z);
                        r_idx     <= '0;
                        r_pend    <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_dx      <= -rad_s;
                        r_dy      <= -rad_s;
                        r_dz      <= -rad_s;
                        if (i_cmd.cmd == CMD_QUERY) begin
                            r_cx    <= from_field(i_cmd.cell_x);
                            r_cy    <= from_field(i_cmd.cell_y);
                            r_cz    <= from_field(i_cmd.cell_z);
                            r_state <= S_LOOK;
                        end else if (r_enable) begin
                            r_cx    <= add_off(from_field(i_cmd.cell_x), -rad_s);
                            r_cy    <= add_off(from_field(i_cmd.cell_y), -rad_s);
                            r_cz    <= add_off(from_field(i_cmd.cell_z), -rad_s);
                            r_state <= S_LOOK;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_LOOK: begin
                    r_pend <= (r_idx < r_entries);
                    r_pidx <= r_idx[AW-1:0];
                    if (r_idx < r_entries) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (hit || miss) begin
                        r_state <= (r_cmd == CMD_QUERY) ? S_QANS : S_CAND;
                    end
                    if (hit) begin
                        r_slot  <= r_pidx;
                        r_found <= 1'b1;
                    end else if (wr_en) begin
                        r_slot    <= r_entries[AW-1:0];
                        r_found   <= 1'b1;
                        r_res[r_entries[AW-1:0]] <= 1'b0;
                        r_entries <= r_entries + 1'b1;
                    end else if (miss) begin
                        r_found <= 1'b0;
                    end
                end
                S_QANS: begin
                    if (out_free) begin
                        r_state <= S_FINISH;
                    end
                end
                S_CAND: begin
                    if (r_found && !r_res[r_slot] && (!r_best_ok || cand_d < r_bestd)) begin
                        r_best_ok <= 1'b1;
                        r_best    <= r_slot;
                        r_bestd   <= cand_d;
                    end
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    if (done_dx && done_dy && done_dz) begin
                        r_state <= S_LOAD_RD;
                    end else begin
                        r_dx    <= nx;
                        r_dy    <= ny;
                        r_dz    <= nz;
                        r_cx    <= add_off(r_qx, nx);
                        r_cy    <= add_off(r_qy, ny);
                        r_cz    <= add_off(r_qz, nz);
                        r_state <= S_LOOK;
                    end
                end
                S_LOAD_RD: begin
                    r_idx   <= '0;
                    r_state <= r_best_ok ? S_LOAD : S_SW_RD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_res[r_best] <= 1'b1;
                        r_active      <= r_active + 1'b1;
                        r_state       <= S_SW_RD;
                    end
                end
                S_SW_RD: begin
                    r_state <= (r_idx >= r_entries) ? S_FINISH : S_SW_CHK;
                end
                S_SW_CHK: begin
                    if (out_free) begin
                        if (produce) begin
                            r_res[r_idx[AW-1:0]] <= 1'b0;
                            r_active <= r_active - 1'b1;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SW_RD;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out   <= fin_res;
                        r_stg_v <= 1'b0;
                        r_nres  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result port.
    assign o_res.valid        = r_ov;
    assign o_res.event_kind   = r_out.event_kind;
    assign o_res.slot         = r_out.slot;
    assign o_res.event_x      = r_out.event_x;
    assign o_res.event_y      = r_out.event_y;
    assign o_res.event_z      = r_out.event_z;
    assign o_res.is_loaded    = r_out.is_loaded;
    assign o_res.slot_found   = r_out.slot_found;
    assign o_res.active_cells = r_out.active_cells;
    assign o_res.last         = r_out.last;

    // Consistency checks on the sequencer.
    `CRM_ASSERT(a_active_le_entries, i_clk, i_rst_n, r_active <= ACT_W'(r_entries), "more resident cells than entries")
    `CRM_ASSERT(a_nres_cap, i_clk, i_rst_n, r_nres <= ACT_W'(MAX_RESULTS), "result count past its cap")
    `CRM_ASSERT(a_load_has_best, i_clk, i_rst_n, (r_state != S_LOAD) || r_best_ok, "load without a candidate")
    `CRM_ASSERT_NEXT(a_finish_last, i_clk, i_rst_n, (r_state == S_FINISH) && out_free, r_ov && r_out.last && !r_stg_v, "request closed without a final result")
endmodule
